// ===== rtl/chained_hash_table_engine_unit_macros.svh =====
// Assertion macros used by the RTL.
`ifndef CHAINED_HASH_TABLE_ENGINE_UNIT_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define CHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cht_pkg.sv =====
`timescale 1ns / 1ps
package cht_pkg;
  localparam int NUM_BUCKETS_DEF = 64;
  localparam int CHAIN_DEPTH_DEF = 16;
  localparam int KEY_W = 31;
  localparam int CMD_W = 2;
  localparam int STATUS_W = 3;
  localparam int CMP_W = 5;
  localparam int CFG_W = 7;
  localparam int CFG_RESET = 64;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_FOUND = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ELEMENT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;
endpackage

// ===== rtl/cht_ram.sv =====
`timescale 1ns / 1ps
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/chained_hash_table_engine_unit.sv =====
`timescale 1ns / 1ps
// Chained hash table engine.
// s_axis_*: one command transaction per operation (insert, search, update, delete).
// m_axis_*: result transactions; tlast marks the final result of a command.
// cfg_*: bucket_count write, only while the block is idle.
// Hashing runs a restoring modulo over the 31-bit key, one bit a cycle,
// then the chain length is read from the length RAM.
// An insert appends the key and goes back to idle with no result, or reports
// full. Search, update and delete walk the chain and report not found on a
// miss. A search hit returns found; an update writes the new value and then
// emits every element of the chain; a delete shifts the later slots down,
// then emits the remaining elements, or reports empty if none is left.
// Only one command is in flight; s_axis_tready is high in the idle state,
// also while a result still waits in the output register.
// Reset sets bucket_count to 64 and starts a clearing pass that zeroes the
// length RAM with both input channels held off; the slot RAM needs no
// clearing, as only slots within a chain's length are read.
// A receiver stall holds the result register and the walk waits behind it.
module chained_hash_table_engine_unit
  import cht_pkg::*;
#(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int CHAIN_DEPTH = CHAIN_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: cmd[1:0], key[32:2], new_value[63:33]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: status[2:0], value[33:3], compare_count[38:34], zero fill
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);
  `include "chained_hash_table_engine_unit_macros.svh"

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int LW = $clog2(CHAIN_DEPTH + 1);
  localparam int AW = $clog2(NUM_BUCKETS * CHAIN_DEPTH);
  localparam int MW = $clog2(NUM_BUCKETS + 1);
  localparam int KCW = $clog2(KEY_W + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MOD = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_SRCH = 4'd3; // read issued for slot idx
  localparam logic [3:0] S_CMP = 4'd4;  // compare rdata
  localparam logic [3:0] S_SHRD = 4'd5;
  localparam logic [3:0] S_SHWR = 4'd6;
  localparam logic [3:0] S_ERD = 4'd7;
  localparam logic [3:0] S_EOUT = 4'd8;
  localparam logic [3:0] S_ONE = 4'd9;
  localparam logic [3:0] S_LEN = 4'd10; // length RAM data valid
  localparam logic [3:0] S_CLR = 4'd11; // clearing pass after reset

  logic [3:0] state;
  logic [CFG_W-1:0] bucket_count;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key, new_value;
  logic [KEY_W-1:0] dividend;
  logic [MW-1:0] rem;
  logic [KCW-1:0] bitcnt;
  logic [MW-1:0] divisor;
  logic [BW-1:0] bucket;
  logic [LW-1:0] len;
  logic [LW-1:0] idx;
  logic [BW-1:0] clr_addr;

  logic out_valid, out_last;
  logic [STATUS_W-1:0] out_status;
  logic [KEY_W-1:0] out_value;
  logic [CMP_W-1:0] out_cmp;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [KEY_W-1:0] ram_wdata, ram_rdata;

  logic len_we;
  logic [BW-1:0] len_waddr;
  logic [LW-1:0] len_wdata, len_rdata;

  // Effective divisor: 0 -> 1, saturate at NUM_BUCKETS.
  always_comb begin
    if (bucket_count == '0) divisor = MW'(1);
    else if (32'(bucket_count) > NUM_BUCKETS) divisor = MW'(NUM_BUCKETS);
    else divisor = MW'(bucket_count);
  end

  logic [MW:0] rem_sh;
  assign rem_sh = {rem, dividend[KEY_W-1]};

  function automatic logic [AW-1:0] slot_addr(input logic [BW-1:0] b,
                                              input logic [LW-1:0] i);
    slot_addr = AW'(32'(b) * CHAIN_DEPTH + 32'(i));
  endfunction

  logic out_free;
  assign out_free = !out_valid || m_axis_tready;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  cht_ram #(.WIDTH(KEY_W), .DEPTH(NUM_BUCKETS * CHAIN_DEPTH)) u_slots (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // rem holds the bucket from the end of the modulo until the next command
  cht_ram #(.WIDTH(LW), .DEPTH(NUM_BUCKETS)) u_lens (
    .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .raddr(BW'(rem)), .rdata(len_rdata)
  );

  logic [LW-1:0] idx_p1;
  assign idx_p1 = idx + LW'(1);

  // RAM control.
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = slot_addr(bucket, idx);
    ram_wdata = key;
    ram_raddr = slot_addr(bucket, idx);
    len_we = 1'b0;
    len_waddr = bucket;
    len_wdata = len + LW'(1);
    case (state)
      S_CLR: begin
        len_we = 1'b1;
        len_waddr = clr_addr;
        len_wdata = '0;
      end
      S_ONE: begin
        if (cmd == CMD_INSERT && len < LW'(CHAIN_DEPTH)) begin
          ram_we = 1'b1;
          ram_waddr = slot_addr(bucket, len);
          len_we = 1'b1;
        end
      end
      S_CMP: begin
        if (ram_rdata == key && cmd == CMD_UPDATE) begin
          ram_we = 1'b1;
          ram_wdata = new_value;
        end
      end
      S_SHRD: begin
        ram_raddr = slot_addr(bucket, idx_p1);
        if (idx_p1 >= len) begin
          len_we = 1'b1;
          len_wdata = len - LW'(1);
        end
      end
      S_SHWR: begin
        ram_we = 1'b1;
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    logic load;
    load = 1'b0;
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      bucket_count <= CFG_W'(CFG_RESET);
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) bucket_count <= cfg_data;
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + BW'(1);
          if (clr_addr == BW'(NUM_BUCKETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            cmd <= s_axis_tdata[1:0];
            key <= s_axis_tdata[32:2];
            new_value <= s_axis_tdata[63:33];
            dividend <= s_axis_tdata[32:2];
            rem <= '0;
            bitcnt <= '0;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          // one restoring-division step per cycle
          if (rem_sh >= {1'b0, divisor}) rem <= MW'(rem_sh - {1'b0, divisor});
          else rem <= MW'(rem_sh);
          dividend <= {dividend[KEY_W-2:0], 1'b0};
          bitcnt <= bitcnt + KCW'(1);
          if (bitcnt == KCW'(KEY_W - 1)) state <= S_DISP;
        end
        S_DISP: begin
          // length RAM read of the bucket is in flight
          bucket <= BW'(rem);
          idx <= '0;
          state <= S_LEN;
        end
        S_LEN: begin
          len <= len_rdata;
          state <= S_ONE;
        end
        S_ONE: begin
          if (cmd == CMD_INSERT) begin
            if (len >= LW'(CHAIN_DEPTH)) begin
              if (out_free) begin
                load = 1'b1; out_status <= ST_FULL; out_value <= '0;
                out_cmp <= '0; out_last <= 1'b1; state <= S_IDLE;
              end
            end else begin
              state <= S_IDLE;
            end
          end else if (len == '0) begin
            if (out_free) begin
              load = 1'b1; out_status <= ST_NOT_FOUND; out_value <= '0;
              out_cmp <= '0; out_last <= 1'b1; state <= S_IDLE;
            end
          end else begin
            state <= S_SRCH;
          end
        end
        S_SRCH: state <= S_CMP;
        S_CMP: begin
          if (ram_rdata == key) begin
            if (cmd == CMD_SEARCH) begin
              if (out_free) begin
                load = 1'b1; out_status <= ST_FOUND; out_value <= '0;
                out_cmp <= CMP_W'(idx_p1); out_last <= 1'b1; state <= S_IDLE;
              end
            end else if (cmd == CMD_UPDATE) begin
              idx <= '0;
              state <= S_ERD;
            end else begin
              state <= S_SHRD;
            end
          end else if (idx_p1 == len) begin
            if (out_free) begin
              load = 1'b1; out_status <= ST_NOT_FOUND; out_value <= '0;
              out_cmp <= '0; out_last <= 1'b1; state <= S_IDLE;
            end
          end else begin
            idx <= idx_p1;
            state <= S_SRCH;
          end
        end
        S_SHRD: begin
          if (idx_p1 >= len) begin
            len <= len - LW'(1);
            idx <= '0;
            state <= S_ERD;
          end else begin
            state <= S_SHWR;
          end
        end
        S_SHWR: begin
          idx <= idx_p1;
          state <= S_SHRD;
        end
        S_ERD: begin
          if (len == '0) begin
            if (out_free) begin
              load = 1'b1; out_status <= ST_EMPTY; out_value <= '0;
              out_cmp <= '0; out_last <= 1'b1; state <= S_IDLE;
            end
          end else begin
            state <= S_EOUT;
          end
        end
        S_EOUT: begin
          // ram_raddr keeps idx, so rdata stays valid while stalled
          if (out_free) begin
            load = 1'b1; out_status <= ST_ELEMENT; out_value <= ram_rdata;
            out_cmp <= '0; out_last <= (idx_p1 == len);
            if (idx_p1 == len) state <= S_IDLE;
            else begin
              idx <= idx_p1;
              state <= S_ERD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (load) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast = out_last;
  assign m_axis_tdata = {1'b0, out_cmp, out_value, out_status};

  `CHT_ASSERT_IMP(a_no_accept_busy, clk, rst, state != S_IDLE, !s_axis_tready,
    "input accepted while busy")
  `CHT_ASSERT_IMP(a_len_bound, clk, rst, state == S_ONE, len <= LW'(CHAIN_DEPTH),
    "chain length over depth")
  `CHT_ASSERT_NEXT(a_hold, clk, rst, out_valid && !m_axis_tready,
    out_valid && $stable(out_value) && $stable(out_last), "result dropped")
  `CHT_ASSERT_IMP(a_status, clk, rst, out_valid, out_status <= ST_FULL,
    "bad status code")
endmodule
